/* hdl/mf3_pkg.sv */
`timescale 1ns / 1ps
// mf3_pkg: shared widths, constants and types for the 3x3 median filter.
// No dependencies; imported by every module of the block except mf3_ram.
package mf3_pkg;

	localparam int PIX_W            = 8;
	localparam int POS_W            = 11;
	localparam int CFG_W            = 12;
	localparam int APB_DATA_W       = 32;
	localparam int APB_ADDR_W       = 3;

	localparam int DEF_MAX_WIDTH    = 2048;
	localparam int HEIGHT_LIMIT     = 2048;
	localparam int MIN_DIM          = 3;
	localparam int DEF_FRAME_WIDTH  = 1920;
	localparam int DEF_FRAME_HEIGHT = 1080;

	localparam int WIN_DIM          = 3;
	localparam int WIN_TAPS         = 9;
	localparam int MEDIAN_RANK      = 5;
	localparam int CNT_W            = $clog2(WIN_TAPS + 1);

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [WIN_TAPS-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic emit;
		logic zero;
		logic done;
		pos_t row;
		pos_t col;
	} meta_t;

	typedef struct packed {
		pix_t filtered;
		pos_t row;
		pos_t col;
		logic done;
	} res_t;

endpackage

/* hdl/mf3_ram.sv */
`timescale 1ns / 1ps
// mf3_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/mf3_median.sv */
`timescale 1ns / 1ps
// mf3_median: two-stage rank select of the 3x3 window (compare matrix, then count/select).
// Depends on mf3_pkg.
module mf3_median (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  mf3_pkg::win_t  win,
	input  mf3_pkg::meta_t meta_in,
	output logic          res_valid,
	output mf3_pkg::res_t  res
);

	import mf3_pkg::*;

	logic [WIN_TAPS-1:0][WIN_TAPS-1:0] lt_c, lt_s3;
	win_t  win_s3;
	meta_t meta_s3, meta_s4;
	logic  v_s3, v_s4;
	pix_t  med_c, med_s4;

	// lt[a][b]: tap b is strictly below tap a
	always_comb begin
		for (int a = 0; a < WIN_TAPS; a++) begin
			for (int b = 0; b < WIN_TAPS; b++) begin
				lt_c[a][b] = (win[b] < win[a]);
			end
		end
	end

	always_comb begin
		logic [WIN_TAPS-1:0] above_vec;
		logic [CNT_W-1:0]    below, above;
		med_c = '0;
		for (int a = WIN_TAPS - 1; a >= 0; a--) begin
			for (int b = 0; b < WIN_TAPS; b++) begin
				above_vec[b] = lt_s3[b][a];
			end
			below = CNT_W'($countones(lt_s3[a]));
			above = CNT_W'($countones(above_vec));
			if (below < CNT_W'(MEDIAN_RANK) && above <= CNT_W'(WIN_TAPS - MEDIAN_RANK)) begin
				med_c = win_s3[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lt_s3   <= lt_c;
			win_s3  <= win;
			meta_s3 <= meta_in;
			med_s4  <= med_c;
			meta_s4 <= meta_s3;
		end
	end

	assign res_valid    = v_s4 && meta_s4.emit;
	assign res.filtered = meta_s4.zero ? '0 : med_s4;
	assign res.row      = meta_s4.row;
	assign res.col      = meta_s4.col;
	assign res.done     = meta_s4.done;

	a_two_advances_reach_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_in) ##1 en |=> v_s4)
		else $error("median: request lost between window and result stage");

endmodule

/* hdl/mf3_out_skid.sv */
`timescale 1ns / 1ps
// mf3_out_skid: output register plus one skid entry; stalls the pipeline when the skid fills.
// Depends on mf3_pkg.
module mf3_out_skid (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	input  mf3_pkg::res_t push_data,
	output logic         en,
	output logic         out_valid,
	input  logic         out_ready,
	output mf3_pkg::res_t out_data
);

	import mf3_pkg::*;

	logic ov_q, sv_q;
	res_t od_q, sd_q;
	logic push;

	assign en   = !sv_q;
	assign push = push_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (out_ready) begin
				sv_q <= 1'b0;
			end
		end else if (push) begin
			if (!ov_q || out_ready) begin
				ov_q <= 1'b1;
			end else begin
				sv_q <= 1'b1;
			end
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (out_ready) begin
				od_q <= sd_q;
			end
		end else if (push) begin
			if (!ov_q || out_ready) begin
				od_q <= push_data;
			end else begin
				sd_q <= push_data;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid: skid entry held while output register empty");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sv_q) |-> $past(ov_q && !out_ready && push_valid))
		else $error("skid: skid filled without a blocked output");

endmodule

/* hdl/median_filter_3x3_top.sv */
`timescale 1ns / 1ps
// median_filter_3x3_top: streaming 3x3 median filter, one pixel per clock.
// Path: a completed window's pixel passes s1, win_q, lt_s3, med_s4 and the output register.
// Throughput: 1 pixel per cycle; line stores are read at accept and written back from s1.
// Back-pressure: in_ready drops only while the one-entry output skid is full.
// Reset: async active-low; clears counters, window, valids; config to 1920x1080. No RAM clear.
// Depends on mf3_pkg, mf3_ram, mf3_median, mf3_out_skid.
module median_filter_3x3_top #(
	parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mf3_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [mf3_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [mf3_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mf3_pkg::PIX_W-1:0]         pixel,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mf3_pkg::PIX_W-1:0]         filtered,
	output logic [mf3_pkg::POS_W-1:0]         out_row,
	output logic [mf3_pkg::POS_W-1:0]         out_col,
	output logic                              frame_done
);

	import mf3_pkg::*;

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WQ_W = CFG_W + 1;
	localparam logic [WQ_W-1:0]  W_MAX  = WQ_W'(MAX_WIDTH);
	localparam logic [WQ_W-1:0]  W_RST  = (DEF_FRAME_WIDTH > MAX_WIDTH) ?
		WQ_W'(MAX_WIDTH) : WQ_W'(DEF_FRAME_WIDTH);
	localparam logic [CFG_W-1:0] H_MAX  = CFG_W'(HEIGHT_LIMIT);

	// configuration
	logic [CFG_W-1:0] fw_q, fh_q, h_q, h_clamp;
	logic [WQ_W-1:0]  w_q, w_clamp;
	logic             cfg_wr;
	reg_idx_t         reg_idx;

	// position and pipeline
	logic             en, acc;
	pos_t             r_q, c_q, r_cur, c_cur, r_nxt, c_nxt;
	logic [AW-1:0]    a_q, a_cur, a_nxt;
	logic [POS_W:0]   c_inc, r_inc;
	logic             wrap;
	meta_t            meta_c, meta_s1, meta_s2;
	logic             valid_s1, hit_s1, valid_s2;
	pix_t             pix_s1;
	logic [AW-1:0]    addr_s1;
	pix_t             ram_up_rd, ram_mid_rd, up_eff, mid_eff;
	pix_t             wr_up_s2, wr_mid_s2;
	win_t             win_q;
	logic             res_valid;
	res_t             res, out_data;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= CFG_W'(DEF_FRAME_WIDTH);
			fh_q <= CFG_W'(DEF_FRAME_HEIGHT);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  fw_q <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= pwdata[CFG_W-1:0];
				default:          fw_q <= fw_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(fw_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(fh_q);
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		if ({1'b0, fw_q} < WQ_W'(MIN_DIM)) begin
			w_clamp = WQ_W'(MIN_DIM);
		end else if ({1'b0, fw_q} > W_MAX) begin
			w_clamp = W_MAX;
		end else begin
			w_clamp = {1'b0, fw_q};
		end
		if (fh_q < CFG_W'(MIN_DIM)) begin
			h_clamp = CFG_W'(MIN_DIM);
		end else if (fh_q > H_MAX) begin
			h_clamp = H_MAX;
		end else begin
			h_clamp = fh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_RST;
			h_q <= CFG_W'(DEF_FRAME_HEIGHT);
		end else begin
			w_q <= w_clamp;
			h_q <= h_clamp;
		end
	end

	// position counters; a_q tracks col modulo the line store depth
	assign in_ready = en;
	assign acc      = in_valid && in_ready;

	always_comb begin
		r_cur = frame_start ? '0 : r_q;
		c_cur = frame_start ? '0 : c_q;
		a_cur = frame_start ? '0 : a_q;
		c_inc = {1'b0, c_cur} + 1'b1;
		r_inc = {1'b0, r_cur} + 1'b1;
		wrap  = ({1'b0, c_inc} >= w_q);
		c_nxt = wrap ? '0 : c_inc[POS_W-1:0];
		if (!wrap) begin
			r_nxt = r_cur;
		end else if (r_inc >= h_q) begin
			r_nxt = '0;
		end else begin
			r_nxt = r_inc[POS_W-1:0];
		end
		if (c_nxt == '0 || a_cur == AW'(MAX_WIDTH - 1)) begin
			a_nxt = '0;
		end else begin
			a_nxt = a_cur + 1'b1;
		end
		meta_c.emit = (r_cur != '0) && (c_cur != '0);
		meta_c.zero = (r_cur < POS_W'(2)) || (c_cur < POS_W'(2));
		meta_c.row  = r_cur - 1'b1;
		meta_c.col  = c_cur - 1'b1;
		meta_c.done = ({1'b0, r_cur} == h_q - 1'b1) && ({2'b00, c_cur} == w_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			a_q <= '0;
		end else if (acc) begin
			r_q <= r_nxt;
			c_q <= c_nxt;
			a_q <= a_nxt;
		end
	end

	// line stores: read at accept, write back from s1
	mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
		.clk   (clk),
		.we    (valid_s1 && en),
		.waddr (addr_s1),
		.wdata (mid_eff),
		.re    (acc),
		.raddr (a_cur),
		.rdata (ram_up_rd)
	);

	mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_middle (
		.clk   (clk),
		.we    (valid_s1 && en),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (acc),
		.raddr (a_cur),
		.rdata (ram_mid_rd)
	);

	// same-entry read/write in one cycle: take the values being written
	assign up_eff  = hit_s1 ? wr_up_s2  : ram_up_rd;
	assign mid_eff = hit_s1 ? wr_mid_s2 : ram_mid_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
			valid_s2 <= 1'b0;
			win_q    <= '0;
		end else if (en) begin
			valid_s1 <= acc;
			hit_s1   <= acc && valid_s1 && (a_cur == addr_s1);
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				for (int k = 0; k < WIN_DIM; k++) begin
					win_q[k*WIN_DIM]     <= win_q[k*WIN_DIM + 1];
					win_q[k*WIN_DIM + 1] <= win_q[k*WIN_DIM + 2];
				end
				win_q[WIN_DIM - 1]     <= up_eff;
				win_q[2*WIN_DIM - 1]   <= mid_eff;
				win_q[WIN_TAPS - 1]    <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (acc) begin
				pix_s1  <= pixel;
				addr_s1 <= a_cur;
				meta_s1 <= meta_c;
			end
			meta_s2   <= meta_s1;
			wr_up_s2  <= mid_eff;
			wr_mid_s2 <= pix_s1;
		end
	end

	mf3_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_in      (valid_s2),
		.win       (win_q),
		.meta_in   (meta_s2),
		.res_valid (res_valid),
		.res       (res)
	);

	mf3_out_skid u_out_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_data  (res),
		.en         (en),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign filtered   = out_data.filtered;
	assign out_row    = out_data.row;
	assign out_col    = out_data.col;
	assign frame_done = out_data.done;

	a_fwd_source_present: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> valid_s2 && valid_s1)
		else $error("top: line store bypass without a preceding write");

	a_frame_start_col0: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && frame_start |=> valid_s1 && addr_s1 == '0 && !meta_s1.emit)
		else $error("top: frame start did not restart at column zero");

endmodule

/* test/tb_median_filter_3x3_top.sv */
`timescale 1ns / 1ps
// tb_median_filter_3x3_top: self-checking bench for the streaming 3x3 median filter.
// Streams pixel frames, programs frame size over APB, predicts every output in-bench.
// Depends on mf3_pkg and median_filter_3x3_top.
module tb_median_filter_3x3_top;
	import mf3_pkg::*;

	localparam int LINE_DEPTH    = DEF_MAX_WIDTH;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	pix_t                  pixel;
	logic                  frame_start;
	logic                  out_valid;
	logic                  out_ready;
	pix_t                  filtered;
	pos_t                  out_row;
	pos_t                  out_col;
	logic                  frame_done;

	// bench copy of the filter state
	logic [CFG_W-1:0] cfg_width;
	logic [CFG_W-1:0] cfg_height;
	pix_t             upper_line [LINE_DEPTH];
	pix_t             middle_line [LINE_DEPTH];
	pix_t             win [WIN_DIM][WIN_DIM];
	int               row_pos;
	int               col_pos;

	res_t expected_pixels [$];
	res_t head;
	int   fail_count;
	int   send_idle_pct;
	int   sink_stall_pct;
	bit   hold_req;

	median_filter_3x3_top #(
		.MAX_WIDTH(LINE_DEPTH)
	) DUT (
		.*
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	// Advance the bench filter by one accepted pixel; queue the output it produces.
	task automatic filter_pixel(input pix_t pix, input logic fs);
		int   w;
		int   h;
		int   r;
		int   c;
		int   idx;
		int   j;
		int   k;
		pix_t up;
		pix_t mid;
		pix_t tmp;
		pix_t v [WIN_TAPS];
		res_t res;
		w = (cfg_width < MIN_DIM) ? MIN_DIM :
			(cfg_width > LINE_DEPTH) ? LINE_DEPTH : int'(cfg_width);
		h = (cfg_height < MIN_DIM) ? MIN_DIM :
			(cfg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(cfg_height);
		if (fs) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		idx = c % LINE_DEPTH;
		up = upper_line[idx];
		mid = middle_line[idx];
		for (k = 0; k < WIN_DIM; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = pix;
		upper_line[idx] = mid;
		middle_line[idx] = pix;
		if (r >= 1 && c >= 1) begin
			res.row = pos_t'(r - 1);
			res.col = pos_t'(c - 1);
			res.done = (r == h - 1) && (c == w - 1);
			res.filtered = '0;
			if (r >= 2 && c >= 2) begin
				for (k = 0; k < WIN_TAPS; k++)
					v[k] = win[k / WIN_DIM][k % WIN_DIM];
				for (j = 1; j < WIN_TAPS; j++) begin
					tmp = v[j];
					k = j - 1;
					while (k >= 0 && v[k] > tmp) begin
						v[k + 1] = v[k];
						k--;
					end
					v[k + 1] = tmp;
				end
				res.filtered = v[MEDIAN_RANK - 1];
			end
			expected_pixels.push_back(res);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		row_pos = r & 'h7FF;
		col_pos = c & 'h7FF;
	endtask

	// Offer one pixel request, with random idle cycles ahead of it, and wait for acceptance.
	task automatic send_pixel(input pix_t pix, input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= pix;
		frame_start <= fs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		filter_pixel(pix, fs);
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			cfg_width = data[CFG_W-1:0];
		else
			cfg_height = data[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [CFG_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[CFG_W-1:0] !== want)
			report_mismatch(idx == REG_FRAME_WIDTH ? "frame_width read" : "frame_height read",
				want, prdata[CFG_W-1:0]);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame_size(input int w, input int h);
		settle_block();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	task automatic test_register_access();
		check_reg(REG_FRAME_WIDTH, DEF_FRAME_WIDTH);
		check_reg(REG_FRAME_HEIGHT, DEF_FRAME_HEIGHT);
		write_reg(REG_FRAME_WIDTH, 32'hABCD_E7FF);
		write_reg(REG_FRAME_HEIGHT, 32'h5432_1A5A);
		check_reg(REG_FRAME_WIDTH, 12'h7FF);
		check_reg(REG_FRAME_HEIGHT, 12'hA5A);
	endtask

	task automatic test_pixel_extremes();
		pix_t pattern [25] = '{
			8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
			8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
			8'd7,   8'd7,   8'd7,   8'd7,   8'd128,
			8'd0,   8'd0,   8'd255, 8'd255, 8'd1,
			8'd200, 8'd100, 8'd50,  8'd25,  8'd12
		};
		send_idle_pct = 0;
		sink_stall_pct = 0;
		set_frame_size(5, 5);
		foreach (pattern[i])
			send_pixel(pattern[i], i == 0);
	endtask

	// frame rolls over on its own, then a restart lands in the middle of a row
	task automatic test_frame_wrap();
		set_frame_size(4, 3);
		for (int i = 0; i < 24; i++)
			send_pixel($urandom_range(255), i == 0);
		for (int i = 0; i < 6; i++)
			send_pixel($urandom_range(255), 1'b0);
		for (int i = 0; i < 12; i++)
			send_pixel($urandom_range(255), i == 0);
	endtask

	task automatic test_size_limits();
		send_idle_pct = 0;
		sink_stall_pct = 0;
		set_frame_size(3, 2048);
		check_reg(REG_FRAME_WIDTH, 12'd3);
		check_reg(REG_FRAME_HEIGHT, 12'd2048);
		for (int i = 0; i < 3 * 20; i++)
			send_pixel($urandom_range(255), i == 0);
		set_frame_size(4095, 2);
		check_reg(REG_FRAME_WIDTH, 12'hFFF);
		for (int i = 0; i < 64; i++)
			send_pixel($urandom_range(255), i == 0);
		set_frame_size(0, 1);
		for (int i = 0; i < 18; i++)
			send_pixel($urandom_range(255), i == 0);
	endtask

	// shrink the frame while the counters sit past the new width
	task automatic test_resize_midframe();
		set_frame_size(8, 6);
		for (int i = 0; i < 30; i++)
			send_pixel($urandom_range(255), i == 0);
		set_frame_size(5, 4);
		for (int i = 0; i < 30; i++)
			send_pixel($urandom_range(255), 1'b0);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		sink_stall_pct = 0;
		set_frame_size(10, 6);
		hold_req = 1'b1;
		for (int i = 0; i < 60; i++)
			send_pixel($urandom_range(255), i == 0);
		settle_block();
		for (int i = 0; i < 25; i++)
			send_pixel($urandom_range(255), i == 0);
		settle_block();
		for (int i = 0; i < 35; i++)
			send_pixel($urandom_range(255), 1'b0);
	endtask

	task automatic test_random_frames(input int idle_pct, input int stall_pct, input int quota);
		int                    sent;
		int                    w_reg;
		int                    h_reg;
		int                    ew;
		int                    eh;
		int                    frames;
		int                    cut;
		int                    stop;
		int                    mode;
		int                    base;
		logic [APB_DATA_W-1:0] data;
		pix_t                  pix;
		logic                  fs;
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < quota) begin
			settle_block();
			w_reg = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
			h_reg = $urandom_range(0, 8);
			data = $urandom();
			data[CFG_W-1:0] = w_reg;
			write_reg(REG_FRAME_WIDTH, data);
			data = $urandom();
			data[CFG_W-1:0] = h_reg;
			write_reg(REG_FRAME_HEIGHT, data);
			ew = (w_reg < MIN_DIM) ? MIN_DIM : w_reg;
			eh = (h_reg < MIN_DIM) ? MIN_DIM : h_reg;
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				mode = $urandom_range(2);
				base = $urandom_range(252);
				cut = ($urandom_range(9) < 2) ? $urandom_range(1, ew * eh - 1) : -1;
				stop = ($urandom_range(9) == 0) ? $urandom_range(1, ew * eh - 1) : ew * eh;
				for (int i = 0; i < stop; i++) begin
					case (mode)
						0: pix = $urandom_range(255);
						1: pix = base + $urandom_range(3);
						default: pix = $urandom_range(1) ? 8'hFF : 8'h00;
					endcase
					fs = (i == 0 && (f == 0 || $urandom_range(1) == 1)) || (i == cut);
					send_pixel(pix, fs);
					sent++;
				end
			end
		end
	endtask

	// result sink: random stalls, or a long hold when requested
	initial begin
		int left;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (left > 0) begin
				out_ready <= 1'b0;
				left--;
			end else
				out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected output, expected none, actual row %0d col %0d value %0d",
					$time, out_row, out_col, filtered);
			end else begin
				head = expected_pixels.pop_front();
				if (filtered !== head.filtered)
					report_mismatch("filtered", head.filtered, filtered);
				if (out_row !== head.row)
					report_mismatch("out_row", head.row, out_row);
				if (out_col !== head.col)
					report_mismatch("out_col", head.col, out_col);
				if (frame_done !== head.done)
					report_mismatch("frame_done", head.done, frame_done);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		out_ready = 1'b0;
		fail_count = 0;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req = 1'b0;
		cfg_width = DEF_FRAME_WIDTH;
		cfg_height = DEF_FRAME_HEIGHT;
		row_pos = 0;
		col_pos = 0;
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		foreach (win[i, j])
			win[i][j] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_pixel_extremes();
		test_frame_wrap();
		test_resize_midframe();
		test_size_limits();
		test_backpressure();
		test_random_frames(0, 0, 360);
		test_random_frames(88, 0, 360);
		test_random_frames(0, 88, 360);
		test_random_frames(37, 37, 360);

		settle_block();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
